/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL of the NACA profile block.
// Self-contained; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/nacafd_pkg.sv */
// Package of the NACA four-digit profile block: widths, register codes,
// pipeline constants and reciprocal tables. No dependencies.
package nacafd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int X_W        = 16;
   localparam int HEIGHT_W   = 18;
   localparam int SLOPE_W    = 19;
   localparam int THICK_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int NSTAGE     = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMBER    = 2'd0,
      CSR_POSITION  = 2'd1,
      CSR_THICKNESS = 2'd2
   } csr_index_type;

   localparam logic [3:0] MAX_DIGIT = 4'd9;
   localparam logic [6:0] MAX_THICK = 7'd99;

   typedef struct packed {
      logic [3:0] cd;   // camber digit, clamped
      logic [3:0] pd;   // position digit, clamped
      logic [6:0] td;   // thickness digits, clamped
   } digits_type;

   // thickness polynomial coefficients, times 10000
   localparam logic [11:0] C_RT = 12'd2969;
   localparam logic [11:0] C_X1 = 12'd1260;
   localparam logic [11:0] C_X2 = 12'd3516;
   localparam logic [11:0] C_X3 = 12'd2843;
   localparam logic [11:0] C_X4 = 12'd1036;

   // final thickness scaling: (num/2^16 + 100000) / 200000, split as /64 then /3125
   localparam logic [16:0] THICK_BIAS  = 17'd100000;
   localparam logic [29:0] THICK_RECIP = 30'd703687442;   // ceil(2^41 / 3125)
   localparam int          THICK_SHIFT = 41;
   localparam int          CAMBER_SHIFT = 34;

   // camber divisor 5*s*s
   function automatic logic [8:0] camber_div(input logic [3:0] s);
      logic [8:0] d;
      case (s)
         4'd2:    d = 9'd20;
         4'd3:    d = 9'd45;
         4'd4:    d = 9'd80;
         4'd5:    d = 9'd125;
         4'd6:    d = 9'd180;
         4'd7:    d = 9'd245;
         4'd8:    d = 9'd320;
         4'd9:    d = 9'd405;
         4'd10:   d = 9'd500;
         default: d = 9'd5;
      endcase
      return d;
   endfunction

   // ceil(2^34 / (5*s*s)), exact floor division for dividends below 2^25
   function automatic logic [31:0] camber_recip(input logic [3:0] s);
      logic [31:0] r;
      case (s)
         4'd2:    r = 32'd858993460;
         4'd3:    r = 32'd381774871;
         4'd4:    r = 32'd214748365;
         4'd5:    r = 32'd137438954;
         4'd6:    r = 32'd95443718;
         4'd7:    r = 32'd70121916;
         4'd8:    r = 32'd53687092;
         4'd9:    r = 32'd42419431;
         4'd10:   r = 32'd34359739;
         default: r = 32'd3435973837;
      endcase
      return r;
   endfunction

endpackage

/* src/nacafd_if.sv */
// Channel interfaces of the NACA profile block: request, response, register write.
// Depends on nacafd_pkg.
interface nacafd_req_if;
   logic                          valid;
   logic                          ready;
   logic [nacafd_pkg::X_W-1:0]    position;
   modport source (output valid, position, input ready);
   modport sink   (input valid, position, output ready);
endinterface

interface nacafd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [nacafd_pkg::HEIGHT_W-1:0] camber_height;
   logic signed [nacafd_pkg::SLOPE_W-1:0]  camber_slope;
   logic        [nacafd_pkg::THICK_W-1:0]  half_thickness;
   modport source (output valid, camber_height, camber_slope, half_thickness, input ready);
   modport sink   (input valid, camber_height, camber_slope, half_thickness, output ready);
endinterface

interface nacafd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [nacafd_pkg::CSR_IDX_W-1:0]  index;
   logic [nacafd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/nacafd_sqrt.sv */
// Pipelined floor square root of x * 2^48 (sqrt x at 32 fraction bits).
// Eight stages, four root bits each. No package dependencies.
module nacafd_sqrt (
   input  logic        clock,
   input  logic [8:1]  load,
   input  logic [15:0] x,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [1:8];
   logic [31:0] root_ff [1:8];
   logic [15:0] x_ff    [1:7];

   for (genvar k = 1; k <= 8; k++) begin : g_stage
      logic [33:0] rem_src;
      logic [31:0] root_src;
      logic [15:0] x_src;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (k == 1) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = x;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign x_src    = x_ff[k-1];
      end

      always_comb begin
         logic [63:0] v;
         logic [35:0] r;
         logic [35:0] t;
         logic [31:0] q;
         v = {x_src, 48'd0};
         r = {2'b00, rem_src};
         q = root_src;
         for (int j = 0; j < 4; j++) begin
            r = {r[33:0], v[2*(31-4*(k-1)-j) +: 2]};
            t = {2'b00, q, 2'b01};
            if (r >= t) begin
               r = r - t;
               q = {q[30:0], 1'b1};
            end else begin
               q = {q[30:0], 1'b0};
            end
         end
         rem_in  = r[33:0];
         root_in = q;
      end

      always_ff @(posedge clock) begin
         if (load[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end

      if (k < 8) begin : g_carry
         always_ff @(posedge clock) begin
            if (load[k]) begin
               x_ff[k] <= x_src;
            end
         end
      end
   end

   assign root = root_ff[8];

endmodule

/* src/nacafd_thick.sv */
// Half-thickness pipeline: powers of x, square root, polynomial, scaling.
// Depends on nacafd_pkg and nacafd_sqrt. Also hands x at stage 8 to the camber path.
module nacafd_thick (
   input  logic                           clock,
   input  logic [nacafd_pkg::NSTAGE:1]    load,
   input  logic [nacafd_pkg::X_W-1:0]     x,
   input  logic [6:0]                     td,
   output logic [nacafd_pkg::X_W-1:0]     x8,
   output logic [nacafd_pkg::THICK_W-1:0] thick
);

   logic [31:0] root;

   logic [15:0] x_ff  [1:8];
   logic [31:0] x2_ff [1:8];
   logic [31:0] x3_ff [2:8];
   logic [31:0] x4_ff [3:8];
   logic [31:0] x2_in;
   logic [47:0] x3_prod;
   logic [47:0] x4_prod;

   logic [43:0] prt9_ff, px19_ff, px29_ff, px39_ff, px49_ff;
   logic [43:0] prt9_in, px19_in, px29_in, px39_in, px49_in;
   logic [44:0] pm10_ff, pm10_in;
   logic [46:0] poly;
   logic [51:0] num11_ff, num11_in;
   logic [36:0] biased;
   logic [60:0] prod12_ff, prod12_in;
   logic [19:0] quot;
   logic [15:0] thick_ff, thick_in;

   nacafd_sqrt u_sqrt (
      .clock (clock),
      .load  (load[8:1]),
      .x     (x),
      .root  (root)
   );

   // x^2 exact, x^3 and x^4 truncated to 32 fraction bits
   assign x2_in   = 32'(x) * 32'(x);
   assign x3_prod = 48'(x2_ff[1]) * 48'(x_ff[1]);
   assign x4_prod = 48'(x3_ff[2]) * 48'(x_ff[2]);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         x_ff[1]  <= x;
         x2_ff[1] <= x2_in;
      end
      if (load[2]) begin
         x_ff[2]  <= x_ff[1];
         x2_ff[2] <= x2_ff[1];
         x3_ff[2] <= x3_prod[47:16];
      end
      if (load[3]) begin
         x_ff[3]  <= x_ff[2];
         x2_ff[3] <= x2_ff[2];
         x3_ff[3] <= x3_ff[2];
         x4_ff[3] <= x4_prod[47:16];
      end
      for (int k = 4; k <= 8; k++) begin
         if (load[k]) begin
            x_ff[k]  <= x_ff[k-1];
            x2_ff[k] <= x2_ff[k-1];
            x3_ff[k] <= x3_ff[k-1];
            x4_ff[k] <= x4_ff[k-1];
         end
      end
   end

   assign x8 = x_ff[8];

   // stage 9: coefficient products
   assign prt9_in = 44'(nacafd_pkg::C_RT) * 44'(root);
   assign px19_in = 44'(27'(nacafd_pkg::C_X1) * 27'(x_ff[8])) << 16;
   assign px29_in = 44'(nacafd_pkg::C_X2) * 44'(x2_ff[8]);
   assign px39_in = 44'(nacafd_pkg::C_X3) * 44'(x3_ff[8]);
   assign px49_in = 44'(nacafd_pkg::C_X4) * 44'(x4_ff[8]);

   // stage 10: polynomial sum, negative or zero clamps to zero
   assign poly    = 47'(prt9_ff) + 47'(px39_ff) - 47'(px19_ff) - 47'(px29_ff) - 47'(px49_ff);
   assign pm10_in = (!poly[46] && (poly != '0)) ? poly[44:0] : '0;

   // stage 11: scale by thickness digits
   assign num11_in = 52'(pm10_ff) * 52'(td);

   // stage 12: round, then divide by 200000 via /64 and reciprocal of 3125
   assign biased    = 37'(num11_ff[51:16]) + 37'(nacafd_pkg::THICK_BIAS);
   assign prod12_in = 61'(biased[36:6]) * 61'(nacafd_pkg::THICK_RECIP);

   // stage 13: quotient and saturation
   assign quot     = prod12_ff[60:nacafd_pkg::THICK_SHIFT];
   assign thick_in = (quot[19:16] != '0) ? 16'hFFFF : quot[15:0];

   always_ff @(posedge clock) begin
      if (load[9]) begin
         prt9_ff <= prt9_in;
         px19_ff <= px19_in;
         px29_ff <= px29_in;
         px39_ff <= px39_in;
         px49_ff <= px49_in;
      end
      if (load[10]) begin
         pm10_ff <= pm10_in;
      end
      if (load[11]) begin
         num11_ff <= num11_in;
      end
      if (load[12]) begin
         prod12_ff <= prod12_in;
      end
      if (load[13]) begin
         thick_ff <= thick_in;
      end
   end

   assign thick = thick_ff;

endmodule

/* src/nacafd_camber.sv */
// Camber height and slope pipeline, stages 9 to 13 of the block.
// Depends on nacafd_pkg (digit struct, divisor and reciprocal tables).
module nacafd_camber (
   input  logic                                  clock,
   input  logic [4:0]                            load,
   input  logic [nacafd_pkg::X_W-1:0]            x,
   input  nacafd_pkg::digits_type                digits,
   output logic signed [nacafd_pkg::HEIGHT_W-1:0] height,
   output logic signed [nacafd_pkg::SLOPE_W-1:0]  slope
);

   logic [19:0] pfix, x10, x5;
   logic        front;

   logic        front9_ff, front10_ff, front11_ff, front12_ff;
   logic [16:0] fa9_ff, fa9_in;
   logic [19:0] fb9_ff, fb9_in;
   logic [19:0] bs9_ff, bs9_in;
   logic [3:0]  s9_ff, s9_in, s10_ff;
   logic [36:0] a10_ff, a10_in;
   logic [24:0] ms10_ff, ms10_in, ms11_ff;
   logic [8:0]  d10, d11;
   logic [41:0] hsum;
   logic [25:0] mh11_ff;
   logic [31:0] r11_ff;
   logic [57:0] ph12_ff, ph12_in;
   logic [56:0] ps12_ff, ps12_in;
   logic [23:0] qh;
   logic [22:0] qs;
   logic signed [17:0] height_ff, height_in;
   logic signed [18:0] slope_ff, slope_in;

   // stage 9: branch select and factors
   assign pfix  = {digits.pd, 16'd0};
   assign x10   = 20'(x) * 20'd10;
   assign x5    = 20'(x) * 20'd5;
   assign front = x10 < pfix;

   assign fa9_in = front ? {1'b0, x} : 17'h10000 - {1'b0, x};
   assign fb9_in = front ? pfix - x5 : 20'd327680 + x5 - pfix;
   assign bs9_in = front ? pfix - x10 : x10 - pfix;
   assign s9_in  = front ? digits.pd : 4'd10 - digits.pd;

   // stage 10: height product, slope dividend with half-divisor rounding
   assign d10     = nacafd_pkg::camber_div(s9_ff);
   assign a10_in  = 37'(fa9_ff) * 37'(fb9_ff);
   assign ms10_in = 25'(bs9_ff) * 25'(digits.cd) + 25'(d10 >> 1);

   // stage 11: height dividend
   assign d11  = nacafd_pkg::camber_div(s10_ff);
   assign hsum = 42'(a10_ff) * 42'(digits.cd) + (42'(d11) << 15);

   // stage 12: reciprocal products
   assign ph12_in = 58'(mh11_ff) * 58'(r11_ff);
   assign ps12_in = 57'(ms11_ff) * 57'(r11_ff);

   // stage 13: quotients, sign and saturation
   assign qh = ph12_ff[57:nacafd_pkg::CAMBER_SHIFT];
   assign qs = ps12_ff[56:nacafd_pkg::CAMBER_SHIFT];

   always_comb begin
      height_in = (qh[23:17] != '0) ? 18'sh1FFFF : $signed({1'b0, qh[16:0]});
      if (front12_ff) begin
         slope_in = (qs[22:18] != '0) ? 19'sh3FFFF : $signed({1'b0, qs[17:0]});
      end else begin
         slope_in = (qs[22:18] != '0) ? 19'sh40000 : $signed(19'd0 - {1'b0, qs[17:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         front9_ff <= front;
         fa9_ff    <= fa9_in;
         fb9_ff    <= fb9_in;
         bs9_ff    <= bs9_in;
         s9_ff     <= s9_in;
      end
      if (load[1]) begin
         front10_ff <= front9_ff;
         a10_ff     <= a10_in;
         ms10_ff    <= ms10_in;
         s10_ff     <= s9_ff;
      end
      if (load[2]) begin
         front11_ff <= front10_ff;
         mh11_ff    <= hsum[41:16];
         ms11_ff    <= ms10_ff;
         r11_ff     <= nacafd_pkg::camber_recip(s10_ff);
      end
      if (load[3]) begin
         front12_ff <= front11_ff;
         ph12_ff    <= ph12_in;
         ps12_ff    <= ps12_in;
      end
      if (load[4]) begin
         height_ff <= height_in;
         slope_ff  <= slope_in;
      end
   end

   assign height = height_ff;
   assign slope  = slope_ff;

endmodule

/* src/naca_four_digit_profile.sv */
// NACA four-digit airfoil evaluator: camber height, camber slope, half thickness.
// Throughput: one transaction per cycle while responses are taken; depth set by the
// 8-stage square root (4 root bits per stage) and 5 multiply and scale stages.
// Reset (synchronous): pipeline emptied, digits return to 0, 0 and 12.
// Depends on nacafd_pkg, nacafd_if, nacafd_thick, nacafd_camber, assert_macros.svh.
`include "assert_macros.svh"

module naca_four_digit_profile (
   input  logic                clock,
   input  logic                reset,
   nacafd_req_if.sink          req_chan,
   nacafd_rsp_if.source        rsp_chan,
   nacafd_csr_if.sink          csr_chan
);

   localparam int N = nacafd_pkg::NSTAGE;

   // ---------------------------------------------------------------
   // Configuration registers. The user must write them only while the
   // pipeline is idle (the block does not enforce it), so the datapath reads them directly.
   // ---------------------------------------------------------------
   logic [3:0] camber_ff;
   logic [3:0] position_ff;
   logic [6:0] thickness_ff;
   nacafd_pkg::digits_type digits;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         camber_ff    <= 4'd0;
         position_ff  <= 4'd0;
         thickness_ff <= 7'd12;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            nacafd_pkg::CSR_CAMBER:    camber_ff    <= csr_chan.data[3:0];
            nacafd_pkg::CSR_POSITION:  position_ff  <= csr_chan.data[3:0];
            nacafd_pkg::CSR_THICKNESS: thickness_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // out-of-range digits act as the largest legal digit
   always_comb begin
      digits.cd = (camber_ff > nacafd_pkg::MAX_DIGIT) ? nacafd_pkg::MAX_DIGIT : camber_ff;
      digits.pd = (position_ff > nacafd_pkg::MAX_DIGIT) ? nacafd_pkg::MAX_DIGIT : position_ff;
      digits.td = (thickness_ff > nacafd_pkg::MAX_THICK) ? nacafd_pkg::MAX_THICK
                                                         : thickness_ff;
   end

   // ---------------------------------------------------------------
   // Pipeline control. Each stage loads when it is empty or when the
   // stage after it loads, so bubbles collapse and a stalled response
   // only backs up as far as the first free slot.
   // ---------------------------------------------------------------
   logic [N:1] v_ff, v_in;
   logic [N:1] en;
   logic       in_acc, out_acc;

   always_comb begin
      en[N] = !v_ff[N] || rsp_chan.ready;
      for (int k = N - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in[1] = en[1] ? req_chan.valid : v_ff[1];
      for (int k = 2; k <= N; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[1];
   assign in_acc         = req_chan.valid && req_chan.ready;
   assign out_acc        = rsp_chan.valid && rsp_chan.ready;

   // ---------------------------------------------------------------
   // Datapath: thickness over stages 1..13, camber over stages 9..13
   // using x carried down the thickness pipe.
   // ---------------------------------------------------------------
   logic [nacafd_pkg::X_W-1:0] x8;

   nacafd_thick u_thick (
      .clock (clock),
      .load  (en),
      .x     (req_chan.position),
      .td    (digits.td),
      .x8    (x8),
      .thick (rsp_chan.half_thickness)
   );

   nacafd_camber u_camber (
      .clock  (clock),
      .load   (en[N:9]),
      .x      (x8),
      .digits (digits),
      .height (rsp_chan.camber_height),
      .slope  (rsp_chan.camber_slope)
   );

   assign rsp_chan.valid = v_ff[N];

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // occupancy now and as it must be after this edge
   logic [4:0] occ, occ_exp;
   assign occ     = 5'($countones(v_ff));
   assign occ_exp = occ + 5'(in_acc) - 5'(out_acc);

   // a stalled output can only admit a transaction if some slot is free
   `ASSERT_IMPLY(a_room_on_stall, clock, reset, req_chan.ready && !rsp_chan.ready, !(&v_ff))
   // reset empties the pipe
   `ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, v_ff == '0)
   // transactions in flight are conserved
   `ASSERT_NEXT(a_conserve, clock, reset, 1'b1, occ == $past(occ_exp))

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the NACA four-digit profile evaluator.
// Depends on nacafd_pkg, nacafd_if and naca_four_digit_profile.
`timescale 1ns / 100ps

module testbench;

   // Expected values of one response transaction
   typedef struct {
      logic signed [nacafd_pkg::HEIGHT_W-1:0] height;
      logic signed [nacafd_pkg::SLOPE_W-1:0]  slope;
      logic        [nacafd_pkg::THICK_W-1:0]  thick;
   } profile_point_type;

   // One row of the directed table: a register write, or a position.
   // When typed is set, the expected values are given in the row.
   typedef struct {
      bit                        is_write;
      nacafd_pkg::csr_index_type idx;
      logic [6:0]                data;
      logic [15:0]               x;
      bit                        typed;
      profile_point_type         want;
   } directed_row_type;

   localparam int DRAIN_CYCLES = 40;    // well past the pipeline length
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nacafd_req_if req_chan ();
   nacafd_rsp_if rsp_chan ();
   nacafd_csr_if csr_chan ();

   naca_four_digit_profile uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #5 clock = ~clock;

   // Shadow copy of the digit registers
   logic [3:0] camber_digit = 4'd0;
   logic [3:0] position_digit = 4'd0;
   logic [6:0] thickness_digits = 7'd12;

   profile_point_type pending_points[$];
   int  errors = 0;
   int  cycles = 0;
   int  items_sent = 0;
   int  points_checked = 0;
   int  writes_done = 0;
   bit  hold_request = 1'b0;   // asks the receiver for one long hold-off

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // round(a*c/d), halves upward
   function automatic longint unsigned scale_round(longint unsigned a, longint unsigned c,
                                                   longint unsigned d);
      longint unsigned q, r;
      q = a / d;
      r = a % d;
      return q * c + (2 * r * c + d) / (2 * d);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned op, res, b;
      op = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > op) b >>= 2;
      while (b != 0) begin
         if (op >= res + b) begin
            op -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic profile_point_type airfoil_point(logic [15:0] xin);
      longint unsigned cd, pd, td, x, one, pfix, k, q, aft, fwd;
      longint unsigned xw, rt, x2, x3, x4, num, den;
      longint h, s, t, poly;
      bit past;
      profile_point_type p;
      cd = (camber_digit > nacafd_pkg::MAX_DIGIT) ? 9 : camber_digit;
      pd = (position_digit > nacafd_pkg::MAX_DIGIT) ? 9 : position_digit;
      td = (thickness_digits > nacafd_pkg::MAX_THICK) ? 99 : thickness_digits;
      x = xin;
      one = 64'd1 << nacafd_pkg::FRAC_BITS;
      pfix = pd * one;
      if (10 * x < pfix) begin
         // front of the maximum camber point
         k = 5 * pd * pd;
         h = longint'(scale_round(x * (pfix - 5 * x), cd, k * one));
         s = longint'(scale_round(pfix - 10 * x, cd, k));
      end else begin
         // aft branch, also the only one when the position digit is zero
         q = 10 - pd;
         k = 5 * q * q;
         past = x > one;
         aft = past ? x - one : one - x;
         fwd = 5 * one + 5 * x - pfix;
         h = longint'(scale_round(aft * fwd, cd, k * one));
         if (past) h = -h;
         s = -longint'(scale_round(10 * x - pfix, cd, k));
      end
      if (x >= one) begin
         t = 0;
      end else begin
         xw = x << (32 - nacafd_pkg::FRAC_BITS);
         rt = floor_root(xw << 32);
         x2 = (xw * xw) >> 32;
         x3 = (x2 * xw) >> 32;
         x4 = (x3 * xw) >> 32;
         poly = 2969 * longint'(rt) - 1260 * longint'(xw) - 3516 * longint'(x2)
              + 2843 * longint'(x3) - 1036 * longint'(x4);
         if (poly <= 0) begin
            t = 0;
         end else begin
            den = 64'd200000 << (32 - nacafd_pkg::FRAC_BITS);
            num = longint'(poly) * td;
            t = longint'((2 * num + den) / (2 * den));
         end
      end
      if (h < -131072) h = -131072;
      if (h > 131071) h = 131071;
      if (s < -262144) s = -262144;
      if (s > 262143) s = 262143;
      if (t > 65535) t = 65535;
      p.height = h[nacafd_pkg::HEIGHT_W-1:0];
      p.slope = s[nacafd_pkg::SLOPE_W-1:0];
      p.thick = t[nacafd_pkg::THICK_W-1:0];
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Response checker: inputs and outputs sampled at the clock edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_points.size() == 0) begin
            $error("response transaction with nothing expected");
            errors++;
         end else begin
            profile_point_type w;
            w = pending_points.pop_front();
            points_checked++;
            if (rsp_chan.camber_height !== w.height) begin
               $error("camber_height expected %0d actual %0d", w.height,
                      rsp_chan.camber_height);
               errors++;
            end
            if (rsp_chan.camber_slope !== w.slope) begin
               $error("camber_slope expected %0d actual %0d", w.slope,
                      rsp_chan.camber_slope);
               errors++;
            end
            if (rsp_chan.half_thickness !== w.thick) begin
               $error("half_thickness expected %0d actual %0d", w.thick,
                      rsp_chan.half_thickness);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int mode, len;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         repeat (len) begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;                       // always taking
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 1) != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 4) == 0);  // mostly stalled
            endcase
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------

   // Offer one position and hold it until the transaction completes;
   // valid stays high, the caller lowers it for a gap.
   task automatic offer_position(input logic [15:0] x);
      req_chan.valid <= 1'b1;
      req_chan.position <= x;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_points.push_back(airfoil_point(x));
      items_sent++;
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Register writes only with the pipeline empty
   task automatic write_digit(input nacafd_pkg::csr_index_type idx, input logic [6:0] data);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         nacafd_pkg::CSR_CAMBER:   camber_digit = data[3:0];
         nacafd_pkg::CSR_POSITION: position_digit = data[3:0];
         default:                  thickness_digits = data;
      endcase
      writes_done++;
   endtask

   // Random register value: mostly legal, sometimes the extremes or over range
   function automatic logic [6:0] pick_digit(input bit thick);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 7'd0;
      if (r == 1) return thick ? 7'd99 : 7'd9;
      if (r == 2) return 7'($urandom_range(0, 127));
      return thick ? 7'($urandom_range(0, 99)) : 7'($urandom_range(0, 9));
   endfunction

   // Random position: uniform, near the ends, or around the maximum camber point
   function automatic logic [15:0] pick_position();
      int r, pivot;
      r = $urandom_range(0, 9);
      pivot = ((position_digit > nacafd_pkg::MAX_DIGIT) ? 9 : position_digit) * 6554;
      case (r)
         0: return 16'($urandom_range(0, 64));
         1: return 16'($urandom_range(65470, 65535));
         2, 3: return 16'(pivot - 32 + $urandom_range(0, 64));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic directed_row_type put(input logic [15:0] x);
      directed_row_type r;
      r.is_write = 1'b0;
      r.idx = nacafd_pkg::CSR_CAMBER;
      r.data = '0;
      r.x = x;
      r.typed = 1'b0;
      r.want.height = '0;
      r.want.slope = '0;
      r.want.thick = '0;
      return r;
   endfunction

   function automatic directed_row_type put_typed(input logic [15:0] x, input int h,
                                                  input int s, input int t);
      directed_row_type r;
      r = put(x);
      r.typed = 1'b1;
      r.want.height = h[nacafd_pkg::HEIGHT_W-1:0];
      r.want.slope = s[nacafd_pkg::SLOPE_W-1:0];
      r.want.thick = t[nacafd_pkg::THICK_W-1:0];
      return r;
   endfunction

   function automatic directed_row_type wr(input nacafd_pkg::csr_index_type idx,
                                           input logic [6:0] d);
      directed_row_type r;
      r = put(16'd0);
      r.is_write = 1'b1;
      r.idx = idx;
      r.data = d;
      return r;
   endfunction

   initial begin
      directed_row_type table_rows[$];
      int phase, burst, gap, n, target;
      bit no_idle;

      req_chan.valid = 1'b0;
      req_chan.position = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = nacafd_pkg::CSR_CAMBER;
      csr_chan.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset digits give a flat camber line
      table_rows.push_back(put_typed(16'd0, 0, 0, 0));
      table_rows.push_back(put_typed(16'hFFFF, 0, 0, 0));
      table_rows.push_back(put(16'd1));
      table_rows.push_back(put(16'h8000));
      // 9499: both branches around the camber point at 0.4
      table_rows.push_back(wr(nacafd_pkg::CSR_CAMBER, 7'd9));
      table_rows.push_back(wr(nacafd_pkg::CSR_POSITION, 7'd4));
      table_rows.push_back(wr(nacafd_pkg::CSR_THICKNESS, 7'd99));
      table_rows.push_back(put(16'd0));
      table_rows.push_back(put(16'd1));
      table_rows.push_back(put(16'd26214));
      table_rows.push_back(put(16'd26215));
      table_rows.push_back(put(16'hFFFF));
      // position digit zero: aft branch everywhere
      table_rows.push_back(wr(nacafd_pkg::CSR_POSITION, 7'd0));
      table_rows.push_back(put(16'd0));
      table_rows.push_back(put(16'hFFFF));
      // over-range digits clamp to 9 and 99
      table_rows.push_back(wr(nacafd_pkg::CSR_CAMBER, 7'd15));
      table_rows.push_back(wr(nacafd_pkg::CSR_POSITION, 7'd127));
      table_rows.push_back(wr(nacafd_pkg::CSR_THICKNESS, 7'd127));
      table_rows.push_back(put(16'd0));
      table_rows.push_back(put(16'd58982));
      table_rows.push_back(put(16'd58983));
      table_rows.push_back(put(16'hFFFF));
      // zero camber, zero thickness
      table_rows.push_back(wr(nacafd_pkg::CSR_CAMBER, 7'd0));
      table_rows.push_back(wr(nacafd_pkg::CSR_THICKNESS, 7'd0));
      table_rows.push_back(put_typed(16'h8000, 0, 0, 0));

      foreach (table_rows[i]) begin
         if (table_rows[i].is_write) begin
            write_digit(table_rows[i].idx, table_rows[i].data);
         end else begin
            offer_position(table_rows[i].x);
            // typed rows replace the predicted values
            if (table_rows[i].typed) pending_points[$] = table_rows[i].want;
            idle_for($urandom_range(0, 2));
         end
      end

      // Random part: phases with fresh digits, bursts with gaps
      for (phase = 0; phase < 12; phase++) begin
         write_digit(nacafd_pkg::CSR_CAMBER, pick_digit(1'b0));
         write_digit(nacafd_pkg::CSR_POSITION, pick_digit(1'b0));
         write_digit(nacafd_pkg::CSR_THICKNESS, pick_digit(1'b1));
         if (phase == 3) hold_request = 1'b1;   // long receiver hold-off, input backs up
         no_idle = (phase % 4 == 1);
         target = 85;
         n = 0;
         while (n < target) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
               if (n < target) begin
                  offer_position(pick_position());
                  n++;
               end
            end
            gap = no_idle ? 0 : $urandom_range(0, 8);
            idle_for(gap);
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d positions sent, %0d responses checked, %0d register writes",
               items_sent, points_checked, writes_done);
      $display("digit settings covered zero, full scale and over-range clamping");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* naca_four_digit_profile.f */
+incdir+src
src/nacafd_pkg.sv
src/nacafd_if.sv
src/nacafd_sqrt.sv
src/nacafd_thick.sv
src/nacafd_camber.sv
src/naca_four_digit_profile.sv
dv/testbench.sv
